/* hw/rtl/ccfc_pkg.sv */
`default_nettype none
package ccfc_pkg;

	localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [15:0] FRAME_OVERHEAD = 16'd8;

	typedef enum logic [2:0] {
		ST_ACK     = 3'd0,
		ST_CRC_ERR = 3'd1,
		ST_NO_ACK  = 3'd2,
		ST_TIMEOUT = 3'd3,
		ST_BAD_LEN = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_CRC     = 2'd2
	} phase_t;

	typedef enum logic {
		FN_BYTE    = 1'b0,
		FN_TIMEOUT = 1'b1
	} func_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] command_index;
		logic [12:0] payload_length;
	} res_t;

	// one byte through crc-32/mpeg-2, msb first
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {b, 24'h00_0000};
		for (int k = 0; k < 8; k++) begin
			c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/ccfc_in_if.sv */
`default_nettype none
interface ccfc_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] data_byte;

	modport source(output valid, output func, output data_byte, input ready);
	modport sink(input valid, input func, input data_byte, output ready);
endinterface
`default_nettype wire

/* hw/rtl/ccfc_out_if.sv */
`default_nettype none
interface ccfc_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] command_index;
	logic [12:0] payload_length;

	modport source(output valid, output status, output command_index,
		output payload_length, input ready);
	modport sink(input valid, input status, input command_index,
		input payload_length, output ready);
endinterface
`default_nettype wire

/* hw/rtl/crc_checked_command_frame_check_unit.sv */
// channel   dir  handshake      payload
// item      in   valid/ready    func, data_byte
// result    out  valid/ready    status, command_index, payload_length
// cfg       in   cfg_we         cfg_wdata (command_count)
//
// one request per cycle unless the result stalls: input register, then frame
// logic into the result register. a byte-wide crc step bounds the frame logic.
// arst_n resets the frame state (crc to CRC_INIT) and clears command_count to zero.
// a stalled result holds the input register; other requests still enter
// while no result is pending.
`default_nettype none
module crc_checked_command_frame_check_unit #(
	parameter int MAX_PAYLOAD = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ccfc_in_if.sink          item,
	ccfc_out_if.source       result,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata
);
	import ccfc_pkg::*;

	logic        valid_s1;
	logic        func_s1;
	logic [7:0]  byte_s1;
	logic [15:0] command_count_q;
	logic        res_valid_q;
	res_t        res_q;
	logic        advance;
	logic        emit;
	res_t        res;

	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_count_q <= '0;
		end else if (cfg_we) begin
			command_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			func_s1 <= item.func;
			byte_s1 <= item.data_byte;
		end
	end

	ccfc_engine #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.func          (func_s1),
		.data_byte     (byte_s1),
		.command_count (command_count_q),
		.emit          (emit),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && emit) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.status         = res_q.status;
	assign result.command_index  = res_q.command_index;
	assign result.payload_length = res_q.payload_length;

endmodule
`default_nettype wire

/* hw/rtl/ccfc_engine.sv */
`default_nettype none
module ccfc_engine #(
	parameter int MAX_PAYLOAD = 4096
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic             func,
	input  wire logic [7:0]       data_byte,
	input  wire logic [15:0]      command_count,
	output logic                  emit,
	output ccfc_pkg::res_t        res
);
	import ccfc_pkg::*;

	phase_t      phase_q, phase_d, phase_eff;
	logic [15:0] cnt_q, cnt_d, cnt_inc;
	logic [31:0] crc_q, crc_d;
	logic [31:0] run_q, run_d;
	logic [15:0] cmd_q, cmd_d;
	logic [15:0] size_q, size_d;
	logic [31:0] rcv_q, rcv_d;
	logic [15:0] plen;
	logic        clr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			cnt_q   <= '0;
			crc_q   <= CRC_INIT;
			run_q   <= CRC_INIT;
			cmd_q   <= '0;
			size_q  <= '0;
			rcv_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			crc_q   <= crc_d;
			run_q   <= run_d;
			cmd_q   <= cmd_d;
			size_q  <= size_d;
			rcv_q   <= rcv_d;
		end
	end

	always_comb begin
		case (phase_q)
			PH_PAYLOAD: phase_eff = PH_PAYLOAD;
			PH_CRC:     phase_eff = PH_CRC;
			default:    phase_eff = PH_HEADER;
		endcase

		plen    = size_q - FRAME_OVERHEAD;
		cnt_inc = cnt_q + 16'd1;

		phase_d = phase_eff;
		cnt_d   = cnt_q;
		crc_d   = crc_q;
		run_d   = run_q;
		cmd_d   = cmd_q;
		size_d  = size_q;
		rcv_d   = rcv_q;
		clr     = 1'b0;
		emit    = 1'b0;
		res.status         = ST_ACK;
		res.command_index  = cmd_q;
		res.payload_length = plen[12:0];

		if (func == FN_TIMEOUT) begin
			clr = 1'b1;
			if (phase_eff != PH_HEADER) begin
				emit       = 1'b1;
				res.status = ST_TIMEOUT;
			end
		end else begin
			case (phase_eff)
				PH_PAYLOAD: begin
					// crc only advances on whole groups, run tracks the partial group
					run_d = crc_byte(run_q, data_byte);
					if (cnt_q[1:0] == 2'd3) begin
						crc_d = run_d;
					end
					cnt_d = cnt_inc;
					if (cnt_inc >= plen) begin
						cnt_d   = '0;
						phase_d = PH_CRC;
					end
				end
				PH_CRC: begin
					rcv_d = rcv_q | ({24'h00_0000, data_byte} << {cnt_q[1:0], 3'b000});
					cnt_d = cnt_inc;
					if (cnt_q[1:0] == 2'd3) begin
						emit = 1'b1;
						clr  = 1'b1;
						if (rcv_d != crc_q) begin
							res.status = ST_CRC_ERR;
						end else if (cmd_q < command_count) begin
							res.status = ST_ACK;
						end else begin
							res.status = ST_NO_ACK;
						end
					end
				end
				default: begin
					crc_d = crc_byte(crc_q, data_byte);
					run_d = crc_d;
					case (cnt_q[1:0])
						2'd0:    cmd_d = {8'h00, data_byte};
						2'd1:    cmd_d = {data_byte, cmd_q[7:0]};
						2'd2:    size_d = {8'h00, data_byte};
						default: size_d = {data_byte, size_q[7:0]};
					endcase
					res.command_index = cmd_d;
					cnt_d = cnt_inc;
					if (cnt_q[1:0] == 2'd3) begin
						cnt_d = '0;
						if (size_d < FRAME_OVERHEAD ||
							(size_d - FRAME_OVERHEAD) > 16'(MAX_PAYLOAD)) begin
							emit               = 1'b1;
							clr                = 1'b1;
							res.status         = ST_BAD_LEN;
							res.payload_length = '0;
						end else if (size_d == FRAME_OVERHEAD) begin
							phase_d = PH_CRC;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
				end
			endcase
		end

		if (clr) begin
			phase_d = PH_HEADER;
			cnt_d   = '0;
			crc_d   = CRC_INIT;
			run_d   = CRC_INIT;
			cmd_d   = '0;
			size_d  = '0;
			rcv_d   = '0;
		end
	end

endmodule
`default_nettype wire
